/* design/assert_macros.svh */
// Assertion shorthands used by block_buffer_lru_manager_top.
// Depends on nothing; the including file provides clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AST_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* design/bblru_pkg.sv */
// Shared types and codes for the buffer LRU manager.
// Used by bblru_cell and block_buffer_lru_manager_top; depends on nothing.
package bblru_pkg;

    localparam int MAX_IDX_W = 6;   // enough for the largest slot count
    localparam int MAX_AGE_W = 32;  // enough for the widest age counter
    localparam int SLOT_W    = 5;
    localparam int BLK_W     = 16;

    localparam logic [1:0] CMD_ALLOC  = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_DIRTY  = 2'd2;
    localparam logic [1:0] CMD_FLUSH  = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OOB  = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    localparam logic [BLK_W-1:0] BLOCK_LIMIT_RST = 16'd8192;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [BLK_W-1:0] block_num;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot;
        logic              writeback_valid;
        logic [BLK_W-1:0]  writeback_block;
        logic              last;
    } t_out_item;

    // Running search result carried from one cell to the next.
    typedef struct packed {
        logic                 valid;
        logic                 free_found;
        logic [MAX_IDX_W-1:0] free_idx;
        logic                 best_found;
        logic [MAX_AGE_W-1:0] best_age;
        logic [MAX_IDX_W-1:0] best_idx;
        logic                 best_dirty;
        logic [BLK_W-1:0]     best_block;
        logic                 match_found;
        logic [MAX_IDX_W-1:0] match_idx;
        logic                 flush_found;
        logic [MAX_IDX_W-1:0] flush_idx;
        logic [BLK_W-1:0]     flush_block;
    } t_carry;

    // Values broadcast from the controller to every cell.
    typedef struct packed {
        logic [BLK_W-1:0]     blk;
        logic [MAX_IDX_W:0]   start;
        logic                 upd_alloc;
        logic                 upd_dirty;
        logic [MAX_IDX_W-1:0] upd_idx;
    } t_bcast;

endpackage

/* design/bblru_cell.sv */
// One buffer slot: used, dirty, block number and age, plus one search stage.
// Depends on bblru_pkg.
module bblru_cell #(
    parameter int AGE_BITS = 16,
    parameter int IDX      = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bblru_pkg::t_carry i_carry,
    input  bblru_pkg::t_bcast i_bcast,
    output bblru_pkg::t_carry o_carry
);

    localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};
    localparam logic [bblru_pkg::MAX_IDX_W-1:0] MY_IDX = IDX[bblru_pkg::MAX_IDX_W-1:0];
    localparam logic [bblru_pkg::MAX_IDX_W:0] MY_IDX_EXT = IDX[bblru_pkg::MAX_IDX_W:0];

    logic                          r_used;
    logic                          r_dirty;
    logic [bblru_pkg::BLK_W-1:0]   r_block;
    logic [AGE_BITS-1:0]           r_age;
    logic [AGE_BITS-1:0]           w_aged;
    logic [bblru_pkg::MAX_AGE_W-1:0] w_aged_ext;
    bblru_pkg::t_carry             n_carry;
    bblru_pkg::t_carry             r_carry;
    logic                          r_carry_valid;

    assign w_aged     = (r_age == AGE_MAX) ? r_age : r_age + AGE_BITS'(1);
    assign w_aged_ext = bblru_pkg::MAX_AGE_W'(w_aged);

    // The oldest slot is judged on ages as they stand after this allocate's aging.
    always_comb begin
        n_carry = i_carry;
        if (r_used) begin
            if (!i_carry.best_found || w_aged_ext > i_carry.best_age) begin
                n_carry.best_found = 1'b1;
                n_carry.best_age   = w_aged_ext;
                n_carry.best_idx   = MY_IDX;
                n_carry.best_dirty = r_dirty;
                n_carry.best_block = r_block;
            end
            if (!i_carry.match_found && r_block == i_bcast.blk) begin
                n_carry.match_found = 1'b1;
                n_carry.match_idx   = MY_IDX;
            end
            if (!i_carry.flush_found && r_dirty && MY_IDX_EXT >= i_bcast.start) begin
                n_carry.flush_found = 1'b1;
                n_carry.flush_idx   = MY_IDX;
                n_carry.flush_block = r_block;
            end
        end else if (!i_carry.free_found) begin
            n_carry.free_found = 1'b1;
            n_carry.free_idx   = MY_IDX;
        end
    end

    always_ff @(posedge i_clk) begin
        r_carry <= n_carry;
        if (!i_rst_n) begin
            r_carry_valid <= 1'b0;
        end else begin
            r_carry_valid <= i_carry.valid;
        end
    end

    always_comb begin
        o_carry       = r_carry;
        o_carry.valid = r_carry_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_bcast.upd_alloc) begin
            if (i_bcast.upd_idx == MY_IDX) begin
                r_block <= i_bcast.blk;
                r_age   <= '0;
            end else if (r_used) begin
                r_age <= w_aged;
            end
        end
        if (!i_rst_n) begin
            r_used  <= 1'b0;
            r_dirty <= 1'b0;
        end else if (i_bcast.upd_alloc && i_bcast.upd_idx == MY_IDX) begin
            r_used  <= 1'b1;
            r_dirty <= 1'b0;
        end else if (i_bcast.upd_dirty && i_bcast.upd_idx == MY_IDX) begin
            r_dirty <= 1'b1;
        end
    end

endmodule

/* design/block_buffer_lru_manager_top.sv */
// Buffer LRU manager: a chain of SLOTS cells searched by a one-stage-per-cycle wave.
// Allocate, lookup and set-dirty: one wave; its result is registered in S_SCAN and moved
// to the output in S_EMIT, then the next beat is taken in S_IDLE. Out of bound: no wave.
// Flush runs one wave per dirty slot plus one; receiver stalls can hold S_EMIT.
// Synchronous active-low reset frees every slot and sets the block limit to 8192.
// Depends on bblru_pkg, bblru_cell and assert_macros.svh.
`include "assert_macros.svh"

module block_buffer_lru_manager_top #(
    parameter int SLOTS    = 32,
    parameter int AGE_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bblru_pkg::BLK_W-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  bblru_pkg::t_in_item         i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output bblru_pkg::t_out_item        o_out
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT} t_state;

    t_state                          r_state, n_state;
    logic [bblru_pkg::BLK_W-1:0]     r_block_limit;
    logic [1:0]                      r_cmd, n_cmd;
    logic [bblru_pkg::BLK_W-1:0]     r_blk, n_blk;
    logic [bblru_pkg::MAX_IDX_W:0]   r_start, n_start;
    logic                            r_launch, n_launch;
    logic                            r_upd_alloc, n_upd_alloc;
    logic                            r_upd_dirty, n_upd_dirty;
    logic [bblru_pkg::MAX_IDX_W-1:0] r_upd_idx, n_upd_idx;
    bblru_pkg::t_out_item            r_res, n_res;
    logic                            r_more, n_more;
    logic                            r_out_valid, n_out_valid;
    bblru_pkg::t_out_item            r_out, n_out;

    bblru_pkg::t_carry               w_carry [0:SLOTS];
    bblru_pkg::t_carry               w_head;
    bblru_pkg::t_bcast               w_bcast;
    bblru_pkg::t_carry               w_end;
    logic [SLOTS:0]                  w_wave_v;
    logic                            w_in_acc;
    logic [bblru_pkg::MAX_IDX_W-1:0] w_sel;

    always_comb begin
        w_head       = '0;
        w_head.valid = r_launch;
    end

    assign w_carry[0] = w_head;

    assign w_bcast.blk       = r_blk;
    assign w_bcast.start     = r_start;
    assign w_bcast.upd_alloc = r_upd_alloc;
    assign w_bcast.upd_dirty = r_upd_dirty;
    assign w_bcast.upd_idx   = r_upd_idx;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        bblru_cell #(.AGE_BITS(AGE_BITS), .IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_carry (w_carry[g]),
            .i_bcast (w_bcast),
            .o_carry (w_carry[g+1])
        );
    end

    for (genvar g = 0; g <= SLOTS; g++) begin : g_wave
        assign w_wave_v[g] = w_carry[g].valid;
    end

    assign w_end       = w_carry[SLOTS];
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign w_sel       = w_end.free_found ? w_end.free_idx : w_end.best_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_limit <= bblru_pkg::BLOCK_LIMIT_RST;
        end else if (i_cfg_we) begin
            r_block_limit <= i_cfg_data;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_blk       = r_blk;
        n_start     = r_start;
        n_launch    = 1'b0;
        n_upd_alloc = 1'b0;
        n_upd_dirty = 1'b0;
        n_upd_idx   = r_upd_idx;
        n_res       = r_res;
        n_more      = r_more;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_cmd   = i_in.cmd;
                    n_blk   = i_in.block_num;
                    n_start = '0;
                    if (i_in.cmd != bblru_pkg::CMD_FLUSH
                        && i_in.block_num >= r_block_limit) begin
                        n_res        = '0;
                        n_res.status = bblru_pkg::ST_OOB;
                        n_res.last   = 1'b1;
                        n_more       = 1'b0;
                        n_state      = S_EMIT;
                    end else begin
                        n_launch = 1'b1;
                        n_state  = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (w_end.valid) begin
                    n_res      = '0;
                    n_res.last = 1'b1;
                    n_more     = 1'b0;
                    n_state    = S_EMIT;
                    case (r_cmd)
                        bblru_pkg::CMD_ALLOC: begin
                            n_res.slot = w_sel[bblru_pkg::SLOT_W-1:0];
                            if (!w_end.free_found && w_end.best_dirty) begin
                                n_res.writeback_valid = 1'b1;
                                n_res.writeback_block = w_end.best_block;
                            end
                            n_upd_alloc = 1'b1;
                            n_upd_idx   = w_sel;
                        end
                        bblru_pkg::CMD_LOOKUP, bblru_pkg::CMD_DIRTY: begin
                            if (w_end.match_found) begin
                                n_res.slot  = w_end.match_idx[bblru_pkg::SLOT_W-1:0];
                                n_upd_dirty = (r_cmd == bblru_pkg::CMD_DIRTY);
                                n_upd_idx   = w_end.match_idx;
                            end else begin
                                n_res.status = bblru_pkg::ST_MISS;
                            end
                        end
                        default: begin
                            // Flush: report the next dirty slot, then search past it.
                            if (w_end.flush_found) begin
                                n_res.slot            = w_end.flush_idx[bblru_pkg::SLOT_W-1:0];
                                n_res.writeback_valid = 1'b1;
                                n_res.writeback_block = w_end.flush_block;
                                n_res.last            = 1'b0;
                                n_more                = 1'b1;
                                n_start = {1'b0, w_end.flush_idx}
                                          + (bblru_pkg::MAX_IDX_W + 1)'(1);
                            end
                        end
                    endcase
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    if (r_more) begin
                        n_launch = 1'b1;
                        n_state  = S_SCAN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_blk     <= n_blk;
        r_start   <= n_start;
        r_upd_idx <= n_upd_idx;
        r_res     <= n_res;
        r_more    <= n_more;
        r_out     <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_launch    <= 1'b0;
            r_upd_alloc <= 1'b0;
            r_upd_dirty <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_launch    <= n_launch;
            r_upd_alloc <= n_upd_alloc;
            r_upd_dirty <= n_upd_dirty;
            r_out_valid <= n_out_valid;
        end
    end

    // Only one search wave travels the chain at a time.
    `AST_IMP(a_one_wave, i_clk, i_rst_n, 1'b1, $countones(w_wave_v) <= 1)
    // A wave leaves the chain only while the controller waits for it.
    `AST_IMP(a_end_in_scan, i_clk, i_rst_n, w_end.valid, r_state == S_SCAN)
    // Error beats carry no slot and no write-back.
    `AST_IMP(a_err_clean, i_clk, i_rst_n,
             o_out_valid && o_out.status != bblru_pkg::ST_OK,
             !o_out.writeback_valid && o_out.slot == '0 && o_out.last)
    // A slot update never coincides with a wave that could see stale state.
    `AST_IMP(a_upd_quiet, i_clk, i_rst_n, r_upd_alloc || r_upd_dirty,
             $countones(w_wave_v) == 0)

endmodule

/* tb/block_buffer_lru_manager_top_tb.sv */
// Self-checking testbench for block_buffer_lru_manager_top: allocate, lookup, set-dirty
// and flush beats against a slot-table tracker, under random sender gaps and receiver stalls.
// Depends on bblru_pkg and the design files; reads nothing at run time.
`timescale 1ns / 1ps

import bblru_pkg::*;

localparam int NUM_SLOTS = 32;
localparam int AGE_W     = 16;

// Tracks the slot table and holds the result beats the block still owes.
class slot_table_tracker;
    logic [BLK_W-1:0] block_limit;
    bit               used [NUM_SLOTS];
    bit               dirty [NUM_SLOTS];
    logic [BLK_W-1:0] held_block [NUM_SLOTS];
    logic [AGE_W-1:0] age [NUM_SLOTS];
    t_out_item        awaited [$];
    int n_commands, n_results, n_failures;
    int n_evictions, n_evict_wb, n_flush_wb, n_oob, n_miss;

    function new();
        block_limit = BLOCK_LIMIT_RST;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            used[i]       = 1'b0;
            dirty[i]      = 1'b0;
            held_block[i] = '0;
            age[i]        = '0;
        end
    endfunction

    function t_out_item make_result(logic [1:0] status, int slot_idx, logic wb,
                                    logic [BLK_W-1:0] wb_blk, logic last);
        t_out_item r;
        r.status          = status;
        r.slot            = SLOT_W'(slot_idx);
        r.writeback_valid = wb;
        r.writeback_block = wb ? wb_blk : '0;
        r.last            = last;
        return r;
    endfunction

    function void note_command(t_in_item beat);
        int s;
        logic wb;
        logic [BLK_W-1:0] wb_blk;
        n_commands++;
        if (beat.cmd == CMD_FLUSH) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (used[i] && dirty[i]) begin
                    awaited.push_back(make_result(ST_OK, i, 1'b1, held_block[i], 1'b0));
                    n_flush_wb++;
                end
            end
            awaited.push_back(make_result(ST_OK, 0, 1'b0, '0, 1'b1));
            return;
        end
        if (beat.block_num >= block_limit) begin
            awaited.push_back(make_result(ST_OOB, 0, 1'b0, '0, 1'b1));
            n_oob++;
            return;
        end
        if (beat.cmd == CMD_ALLOC) begin
            wb     = 1'b0;
            wb_blk = '0;
            for (int i = 0; i < NUM_SLOTS; i++)
                if (used[i] && age[i] != {AGE_W{1'b1}})
                    age[i] = age[i] + AGE_W'(1);
            s = -1;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (!used[i]) begin
                    s = i;
                    break;
                end
            end
            if (s < 0) begin
                // Table full: the oldest slot goes, lowest index on a tie.
                s = 0;
                for (int i = 1; i < NUM_SLOTS; i++)
                    if (age[i] > age[s])
                        s = i;
                n_evictions++;
                if (dirty[s]) begin
                    wb     = 1'b1;
                    wb_blk = held_block[s];
                    n_evict_wb++;
                end
            end
            used[s]       = 1'b1;
            dirty[s]      = 1'b0;
            held_block[s] = beat.block_num;
            age[s]        = '0;
            awaited.push_back(make_result(ST_OK, s, wb, wb_blk, 1'b1));
            return;
        end
        s = -1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (used[i] && held_block[i] == beat.block_num) begin
                s = i;
                break;
            end
        end
        if (s < 0) begin
            awaited.push_back(make_result(ST_MISS, 0, 1'b0, '0, 1'b1));
            n_miss++;
            return;
        end
        if (beat.cmd == CMD_DIRTY)
            dirty[s] = 1'b1;
        awaited.push_back(make_result(ST_OK, s, 1'b0, '0, 1'b1));
    endfunction

    function void report_failure(string what, t_out_item want, t_out_item got);
        n_failures++;
        if (n_failures <= 10) begin
            $display("%0t %s", $realtime, what);
            $display("    expected status %0d slot %0d wb %0b blk %0d last %0b",
                     want.status, want.slot, want.writeback_valid, want.writeback_block,
                     want.last);
            $display("    actual   status %0d slot %0d wb %0b blk %0d last %0b",
                     got.status, got.slot, got.writeback_valid, got.writeback_block, got.last);
        end
    endfunction

    function void check_result(t_out_item got);
        t_out_item want;
        n_results++;
        if (awaited.size() == 0) begin
            report_failure("result beat with nothing awaited", '0, got);
            return;
        end
        want = awaited.pop_front();
        if (got.status !== want.status || got.slot !== want.slot ||
            got.writeback_valid !== want.writeback_valid ||
            got.writeback_block !== want.writeback_block || got.last !== want.last)
            report_failure("result beat mismatch", want, got);
    endfunction
endclass

module block_buffer_lru_manager_top_tb;

    localparam int RESET_CYCLES    = 11;
    localparam int SETTLE_CYCLES   = NUM_SLOTS + 6;
    localparam int WATCHDOG_CYCLES = 4000;
    localparam int POOL_SIZE       = 40;

    typedef enum {RX_ALWAYS, RX_PATTERN, RX_RANDOM} rx_mode_e;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [BLK_W-1:0] i_cfg_data;
    logic             i_in_valid;
    logic             o_in_ready;
    t_in_item         i_in;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_out_item        o_out;

    slot_table_tracker slot_table;
    int               quiet_cycles = 0;
    int               burst_left = 0;
    logic [BLK_W-1:0] last_limit;

    int          rx_cycle = 0;
    rx_mode_e    rx_mode = RX_ALWAYS;
    logic [11:0] rx_pattern = 12'hFFF;

    block_buffer_lru_manager_top #(
        .SLOTS    (NUM_SLOTS),
        .AGE_BITS (AGE_W)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always #2 i_clk = ~i_clk;

    // Receiver: repeatedly picks at random between always ready, a rotating stall
    // pattern, and random stalls.
    always @(negedge i_clk) begin
        if (rx_cycle % 60 == 0) begin
            rx_mode    = rx_mode_e'($urandom_range(2));
            rx_pattern = 12'($urandom) | 12'h001;
        end
        rx_cycle++;
        case (rx_mode)
            RX_ALWAYS: begin
                i_out_ready <= 1'b1;
            end
            RX_PATTERN: begin
                i_out_ready <= rx_pattern[0];
                rx_pattern = {rx_pattern[0], rx_pattern[11:1]};
            end
            default: begin
                i_out_ready <= ($urandom_range(3) != 0);
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            slot_table.note_command(i_in);
        if (i_rst_n && o_out_valid && i_out_ready)
            slot_table.check_result(o_out);
        if (i_rst_n && ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("Watchdog: no beat accepted for %0d cycles", quiet_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    // Sender works in bursts; between bursts valid drops for a random gap.
    task automatic send_beat(input t_in_item beat);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(3) == 0) ? $urandom_range(10, 45) : $urandom_range(1, 6);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 50)
                                                  : $urandom_range(1, 8);
        end
        burst_left--;
        @(negedge i_clk);
        i_in       <= beat;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_cmd(input logic [1:0] cmd, input logic [BLK_W-1:0] blk);
        t_in_item beat;
        beat.cmd       = cmd;
        beat.block_num = blk;
        send_beat(beat);
    endtask

    task automatic settle();
        while (slot_table.awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_block_limit(input logic [BLK_W-1:0] value);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        settle();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        slot_table.block_limit = value;
    endtask

    task automatic run_directed();
        send_cmd(CMD_FLUSH,  16'd0);      // empty table: only the closing beat
        send_cmd(CMD_LOOKUP, 16'd5);
        send_cmd(CMD_DIRTY,  16'd5);
        send_cmd(CMD_ALLOC,  16'd0);
        send_cmd(CMD_ALLOC,  16'd8191);
        send_cmd(CMD_ALLOC,  16'd8192);
        send_cmd(CMD_ALLOC,  16'hFFFF);
        send_cmd(CMD_LOOKUP, 16'd8192);
        send_cmd(CMD_DIRTY,  16'hFFFF);
        send_cmd(CMD_LOOKUP, 16'd8191);
        send_cmd(CMD_DIRTY,  16'd8191);
        send_cmd(CMD_ALLOC,  16'd0);      // same block now in two slots
        send_cmd(CMD_DIRTY,  16'd0);
        send_cmd(CMD_LOOKUP, 16'd0);
        send_cmd(CMD_FLUSH,  16'd0);
        send_cmd(CMD_ALLOC,  16'd8191);
        send_cmd(CMD_FLUSH,  16'hFFFF);   // flush keeps the dirty flags
        send_cmd(CMD_DIRTY,  16'd8191);
        send_cmd(CMD_FLUSH,  16'h5A5A);
    endtask

    // Mostly commands on a small pool of blocks, in range while the limit is above 0, so
    // that the table fills, evicts and collects dirty slots; the rest is random noise.
    task automatic run_random(input int count);
        logic [BLK_W-1:0] pool [POOL_SIZE];
        t_in_item beat;
        int pick;
        int top;
        top = int'(slot_table.block_limit) - 1;
        for (int k = 0; k < POOL_SIZE; k++)
            pool[k] = (top < 0) ? BLK_W'($urandom) : BLK_W'($urandom_range(top));
        pool[0] = (top < 0) ? '0 : BLK_W'(top);
        pool[1] = '0;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 44)
                beat.cmd = CMD_ALLOC;
            else if (pick < 64)
                beat.cmd = CMD_LOOKUP;
            else if (pick < 88)
                beat.cmd = CMD_DIRTY;
            else if (pick < 93)
                beat.cmd = CMD_FLUSH;
            else
                beat.cmd = 2'($urandom);
            if (pick >= 93 || $urandom_range(9) == 0)
                beat.block_num = BLK_W'($urandom);
            else
                beat.block_num = pool[$urandom_range(POOL_SIZE - 1)];
            send_beat(beat);
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in       = '0;
        slot_table = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        run_random(160);
        set_block_limit(16'hFFFF);
        run_random(120);
        set_block_limit(16'd1);
        run_random(50);
        set_block_limit(16'd0);
        run_random(20);
        last_limit = BLK_W'($urandom_range(2, 40));
        set_block_limit(last_limit);
        run_random(100);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        settle();

        $display("Covered %0d commands, %0d result beats, block limits 8192, 65535, 1, 0, %0d.",
                 slot_table.n_commands, slot_table.n_results, last_limit);
        $display("Evictions %0d (%0d dirty), flush write-backs %0d, out of bound %0d, misses %0d.",
                 slot_table.n_evictions, slot_table.n_evict_wb, slot_table.n_flush_wb,
                 slot_table.n_oob, slot_table.n_miss);
        if (slot_table.awaited.size() != 0)
            $display("%0d result beats never arrived", slot_table.awaited.size());
        if (slot_table.n_failures == 0 && slot_table.awaited.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches in total", slot_table.n_failures);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
